/* hdl/ofd_pkg.sv */
// Shared types, constants and register codes of the optical frame deframer.
package ofd_pkg;

	// Frame geometry
	localparam int FRAME_SAMPLES = 1024;
	localparam int FRAME_BYTES   = FRAME_SAMPLES / 16;
	localparam int CNT_W         = $clog2(FRAME_SAMPLES);
	localparam int IDX_W         = CNT_W - 4;

	// Field widths
	localparam int SAMPLE_W     = 10;
	localparam int THR_W        = SAMPLE_W + 1;
	localparam int BYTE_W       = 8;
	localparam int BYTE_INDEX_W = 6;
	localparam int STATUS_W     = 2;
	localparam int CFG_INDEX_W  = 2;
	localparam int CFG_DATA_W   = 10;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_AMBIENT = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_MARGIN  = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_STATION = 2'd2;

	// Configuration reset values
	localparam logic [SAMPLE_W-1:0] AMBIENT_RESET = 10'd0;
	localparam logic [SAMPLE_W-1:0] MARGIN_RESET  = 10'd100;
	localparam logic [BYTE_W-1:0]   STATION_RESET = 8'd1;

	// Frame status codes
	localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_PREAMBLE  = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_OTHER_DST = 2'd2;

	// Header layout
	localparam logic [BYTE_W-1:0] PREAMBLE_BYTE  = 8'h0F;
	localparam logic [3:0]        BIT_PHASE_LAST = 4'd14;
	localparam logic [IDX_W-1:0]  IDX_PREAMBLE_END = IDX_W'(2);
	localparam logic [IDX_W-1:0]  IDX_LENGTH       = IDX_W'(4);
	localparam logic [IDX_W-1:0]  IDX_DEST         = IDX_W'(5);
	localparam logic [IDX_W-1:0]  IDX_SOURCE       = IDX_W'(6);
	localparam logic [IDX_W-1:0]  IDX_FINAL        = IDX_W'(FRAME_BYTES - 1);
	localparam logic [CNT_W-1:0]  CNT_FINAL        = CNT_W'(FRAME_SAMPLES - 1);

	typedef struct packed {
		logic [SAMPLE_W-1:0] ambient_level;
		logic [SAMPLE_W-1:0] threshold_margin;
		logic [BYTE_W-1:0]   station_address;
	} ofd_cfg_t;

	typedef struct packed {
		logic [BYTE_W-1:0]       byte_value;
		logic [BYTE_INDEX_W-1:0] byte_index;
		logic [STATUS_W-1:0]     frame_status;
		logic [BYTE_W-1:0]       frame_length;
		logic [BYTE_W-1:0]       destination;
		logic [BYTE_W-1:0]       origin_address;
		logic                    last;
	} ofd_result_t;

endpackage

/* hdl/ofd_cfg_regs.sv */
// Configuration register bank of the optical frame deframer.
module ofd_cfg_regs (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              wr_en,
	input  logic [ofd_pkg::CFG_INDEX_W-1:0]   wr_index,
	input  logic [ofd_pkg::CFG_DATA_W-1:0]    wr_data,
	output ofd_pkg::ofd_cfg_t                 cfg
);

	ofd_pkg::ofd_cfg_t cfg_q;

	// Write the addressed register; drop writes beyond the list
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ambient_level    <= ofd_pkg::AMBIENT_RESET;
			cfg_q.threshold_margin <= ofd_pkg::MARGIN_RESET;
			cfg_q.station_address  <= ofd_pkg::STATION_RESET;
		end else if (wr_en) begin
			case (wr_index)
				ofd_pkg::REG_AMBIENT: begin
					cfg_q.ambient_level <= wr_data[ofd_pkg::SAMPLE_W-1:0];
				end
				ofd_pkg::REG_MARGIN: begin
					cfg_q.threshold_margin <= wr_data[ofd_pkg::SAMPLE_W-1:0];
				end
				ofd_pkg::REG_STATION: begin
					cfg_q.station_address <= wr_data[ofd_pkg::BYTE_W-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* hdl/ofd_core.sv */
// Input register, frame state and byte decode of the optical frame deframer.
module ofd_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  ofd_pkg::ofd_cfg_t               cfg,
	input  logic                            in_valid,
	input  logic [ofd_pkg::SAMPLE_W-1:0]    sample,
	input  logic                            out_block,
	output logic                            in_stall,
	output logic                            res_valid,
	output ofd_pkg::ofd_result_t            res
);

	logic                          valid_s1;
	logic [ofd_pkg::SAMPLE_W-1:0]  sample_s1;

	logic                          receiving_q;
	logic [ofd_pkg::CNT_W-1:0]     count_q;
	logic [ofd_pkg::BYTE_W-1:0]    shift_q;
	logic                          pre_bad_q;
	logic [ofd_pkg::BYTE_W-1:0]    length_q;
	logic [ofd_pkg::BYTE_W-1:0]    dest_q;
	logic [ofd_pkg::BYTE_W-1:0]    source_q;

	logic [ofd_pkg::THR_W-1:0]     thr;
	logic [ofd_pkg::THR_W-1:0]     s_ext;
	logic                          start_hit;
	logic                          bit_val;
	logic                          even;
	logic                          byte_done;
	logic [ofd_pkg::BYTE_W-1:0]    shift_next;
	logic [ofd_pkg::IDX_W-1:0]     idx;
	logic                          is_final;
	logic                          advance;
	logic                          byte_out;

	// Threshold compare without wrap
	assign thr       = {1'b0, cfg.ambient_level} + {1'b0, cfg.threshold_margin};
	assign s_ext     = {1'b0, sample_s1};
	assign start_hit = (s_ext >= thr);
	assign bit_val   = !(s_ext > thr);

	// Bit position within the frame
	assign even       = !count_q[0];
	assign byte_done  = even && (count_q[3:0] == ofd_pkg::BIT_PHASE_LAST);
	assign shift_next = {shift_q[ofd_pkg::BYTE_W-2:0], bit_val};
	assign idx        = count_q[ofd_pkg::CNT_W-1:4];
	assign is_final   = (idx == ofd_pkg::IDX_FINAL);

	// Hold the input register only when a byte cannot reach the output register
	assign byte_out  = valid_s1 && receiving_q && byte_done;
	assign in_stall  = byte_out && out_block;
	assign advance   = valid_s1 && !in_stall;
	assign res_valid = byte_out && !out_block;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			sample_s1 <= sample;
		end
	end

	// Frame state: wait for start, then shift in bits and capture the header
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			receiving_q <= 1'b0;
			count_q     <= '0;
			shift_q     <= '0;
			pre_bad_q   <= 1'b0;
			length_q    <= '0;
			dest_q      <= '0;
			source_q    <= '0;
		end else if (advance) begin
			if (!receiving_q) begin
				if (start_hit) begin
					receiving_q <= 1'b1;
					count_q     <= '0;
					shift_q     <= '0;
					pre_bad_q   <= 1'b0;
					length_q    <= '0;
					dest_q      <= '0;
					source_q    <= '0;
				end
			end else begin
				if (even) begin
					shift_q <= shift_next;
				end
				if (byte_done) begin
					if (idx <= ofd_pkg::IDX_PREAMBLE_END
						&& shift_next != ofd_pkg::PREAMBLE_BYTE) begin
						pre_bad_q <= 1'b1;
					end else if (idx == ofd_pkg::IDX_LENGTH) begin
						length_q <= shift_next;
					end else if (idx == ofd_pkg::IDX_DEST) begin
						dest_q <= shift_next;
					end else if (idx == ofd_pkg::IDX_SOURCE) begin
						source_q <= shift_next;
					end
				end
				// End the frame after the last sample
				if (count_q == ofd_pkg::CNT_FINAL) begin
					receiving_q <= 1'b0;
					count_q     <= '0;
				end else begin
					count_q <= count_q + ofd_pkg::CNT_W'(1);
				end
			end
		end
	end

	// Result item; header fields only on the final byte
	always_comb begin
		res                = '0;
		res.byte_value     = shift_next;
		res.byte_index     = ofd_pkg::BYTE_INDEX_W'(idx);
		if (is_final) begin
			res.last           = 1'b1;
			res.frame_length   = length_q;
			res.destination    = dest_q;
			res.origin_address = source_q;
			if (pre_bad_q) begin
				res.frame_status = ofd_pkg::STATUS_PREAMBLE;
			end else if (dest_q != cfg.station_address) begin
				res.frame_status = ofd_pkg::STATUS_OTHER_DST;
			end else begin
				res.frame_status = ofd_pkg::STATUS_OK;
			end
		end
	end

endmodule

/* hdl/optical_frame_deframer.sv */
// Optical frame deframer: sample in, decoded frame bytes out.
//
// Usage. Light-sensor samples enter on in_valid/in_stall with the sample
// field; decoded bytes leave on out_valid/out_stall with byte_value,
// byte_index and, on the item with last set, frame_status, frame_length,
// destination and origin_address. Configuration registers (ambient level,
// threshold margin, station address) are written on cfg_valid/cfg_ready
// with cfg_index and cfg_data; cfg_ready is always high.
// Path: a byte item goes from the input register through the compare and
// shift into the output register, and waits in the input register while
// a held output item is stalled. Throughput: one sample per cycle while
// in_stall is low; the compare and shift between the registers are combinational.
// Reset: configuration returns to its defaults and the block waits idle for
// a start sample; no item is held.
// Stall: the output register keeps its item while out_stall is high; samples
// that complete no byte keep flowing, and in_stall rises only when a finished
// byte meets an occupied, stalled output register.
module optical_frame_deframer (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic [ofd_pkg::SAMPLE_W-1:0]       sample,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [ofd_pkg::BYTE_W-1:0]         byte_value,
	output logic [ofd_pkg::BYTE_INDEX_W-1:0]   byte_index,
	output logic [ofd_pkg::STATUS_W-1:0]       frame_status,
	output logic [ofd_pkg::BYTE_W-1:0]         frame_length,
	output logic [ofd_pkg::BYTE_W-1:0]         destination,
	output logic [ofd_pkg::BYTE_W-1:0]         origin_address,
	output logic                               last,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ofd_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  logic [ofd_pkg::CFG_DATA_W-1:0]     cfg_data
);

	ofd_pkg::ofd_cfg_t     cfg;
	ofd_pkg::ofd_result_t  res;
	ofd_pkg::ofd_result_t  out_q;
	logic                  res_valid;
	logic                  out_valid_q;
	logic                  out_block;

	assign cfg_ready = 1'b1;

	ofd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	ofd_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_valid  (in_valid),
		.sample    (sample),
		.out_block (out_block),
		.in_stall  (in_stall),
		.res_valid (res_valid),
		.res       (res)
	);

	assign out_block = out_valid_q && out_stall;

	// Output register: load a new item, drop a taken one, hold when stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_valid) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid) begin
			out_q <= res;
		end
	end

	assign out_valid      = out_valid_q;
	assign byte_value     = out_q.byte_value;
	assign byte_index     = out_q.byte_index;
	assign frame_status   = out_q.frame_status;
	assign frame_length   = out_q.frame_length;
	assign destination    = out_q.destination;
	assign origin_address = out_q.origin_address;
	assign last           = out_q.last;

	// Input backpressure only comes from a held output item
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("input stalled without a held output item");

	// The final byte carries the final index
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && last) |->
			(byte_index == ofd_pkg::BYTE_INDEX_W'(ofd_pkg::FRAME_BYTES - 1)))
		else $error("last flagged on a byte that is not the final one");

	// Header fields stay clear on bytes other than the final one
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !last) |->
			(frame_status == ofd_pkg::STATUS_OK && frame_length == '0
			&& destination == '0 && origin_address == '0))
		else $error("header fields set on a byte that is not the final one");

	// A new result never overwrites a held item
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(byte_index)))
		else $error("held output item lost or replaced");

endmodule

/* dv/optical_frame_deframer_tb.sv */
// Self-checking testbench for the optical frame deframer: sample stream in, decoded bytes checked.
`timescale 1ns / 1ps

module optical_frame_deframer_tb;
	import ofd_pkg::*;

	localparam int CYCLE_LIMIT  = 300000;
	localparam int HOLD_CYCLES  = 400;
	localparam int DRAIN_CYCLES = 4;
	localparam int MAX_PRINTS   = 50;
	localparam int SAMPLE_MAX   = (1 << SAMPLE_W) - 1;
	localparam int RANDOM_FRAMES = 4;

	// Index beyond the register map; a write there must change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_UNUSED = 2'd3;

	typedef logic [BYTE_W-1:0] frame_bytes_t [FRAME_BYTES];
	typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic                    clk;
	logic                    arst_n;
	logic                    in_valid;
	logic                    in_stall;
	logic [SAMPLE_W-1:0]     sample;
	logic                    out_valid;
	logic                    out_stall;
	logic [BYTE_W-1:0]       byte_value;
	logic [BYTE_INDEX_W-1:0] byte_index;
	logic [STATUS_W-1:0]     frame_status;
	logic [BYTE_W-1:0]       frame_length;
	logic [BYTE_W-1:0]       destination;
	logic [BYTE_W-1:0]       origin_address;
	logic                    last;
	logic                    cfg_valid;
	logic                    cfg_ready;
	logic [CFG_INDEX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0]   cfg_data;

	// Pending samples and predicted bytes
	logic [SAMPLE_W-1:0] sample_queue[$];
	ofd_result_t         byte_expect[$];

	// Shadow configuration
	logic [SAMPLE_W-1:0] cfg_ambient;
	logic [SAMPLE_W-1:0] cfg_margin;
	logic [BYTE_W-1:0]   cfg_station;

	// Shadow decoder state
	logic               rx_active;
	logic [CNT_W-1:0]   rx_count;
	logic [BYTE_W-1:0]  rx_shift;
	logic               rx_preamble_bad;
	logic [BYTE_W-1:0]  rx_length;
	logic [BYTE_W-1:0]  rx_dest;
	logic [BYTE_W-1:0]  rx_source;

	int burst_left = 0;
	int gap_left = 0;
	int hold_req = 0;
	int hold_seen = 0;
	int hold_left = 0;
	int mode_left = 0;
	int stall_tick = 0;
	stall_mode_t stall_mode = STALL_NONE;
	int error_count = 0;
	int samples_taken = 0;
	int bytes_checked = 0;
	int cycle_count = 0;
	int frames_seen[3] = '{0, 0, 0};

	optical_frame_deframer uut (
		.clk, .arst_n,
		.in_valid, .in_stall, .sample,
		.out_valid, .out_stall,
		.byte_value, .byte_index, .frame_status, .frame_length,
		.destination, .origin_address, .last,
		.cfg_valid, .cfg_ready, .cfg_index, .cfg_data
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic logic [THR_W-1:0] light_threshold();
		return {1'b0, cfg_ambient} + {1'b0, cfg_margin};
	endfunction

	// Advance the shadow decoder by one sample; queue the byte it completes
	task automatic decode_sample(input logic [SAMPLE_W-1:0] s);
		logic [THR_W-1:0] thr;
		logic [IDX_W-1:0] idx;
		ofd_result_t      r;
		thr = light_threshold();
		if (!rx_active) begin
			if (THR_W'(s) >= thr) begin
				rx_active = 1'b1;
				rx_count = '0;
				rx_shift = '0;
				rx_preamble_bad = 1'b0;
				rx_length = '0;
				rx_dest = '0;
				rx_source = '0;
			end
		end else begin
			if (!rx_count[0]) begin
				rx_shift = {rx_shift[BYTE_W-2:0], (THR_W'(s) > thr) ? 1'b0 : 1'b1};
				if (rx_count[3:0] == BIT_PHASE_LAST) begin
					idx = rx_count[CNT_W-1:4];
					if (idx <= IDX_PREAMBLE_END && rx_shift != PREAMBLE_BYTE)
						rx_preamble_bad = 1'b1;
					else if (idx == IDX_LENGTH)
						rx_length = rx_shift;
					else if (idx == IDX_DEST)
						rx_dest = rx_shift;
					else if (idx == IDX_SOURCE)
						rx_source = rx_shift;
					r = '0;
					r.byte_value = rx_shift;
					r.byte_index = BYTE_INDEX_W'(idx);
					if (idx == IDX_FINAL) begin
						if (rx_preamble_bad)
							r.frame_status = STATUS_PREAMBLE;
						else if (rx_dest != cfg_station)
							r.frame_status = STATUS_OTHER_DST;
						else
							r.frame_status = STATUS_OK;
						r.frame_length = rx_length;
						r.destination = rx_dest;
						r.origin_address = rx_source;
						r.last = 1'b1;
					end
					byte_expect.push_back(r);
				end
			end
			if (rx_count == CNT_FINAL) begin
				rx_active = 1'b0;
				rx_count = '0;
			end else begin
				rx_count = rx_count + CNT_W'(1);
			end
		end
	endtask

	task automatic report_mismatch(input string msg);
		if (error_count < MAX_PRINTS)
			$display("optical_frame_deframer_tb: error at %0t: %s", $time, msg);
		error_count++;
	endtask

	task automatic check_field(input string name, input int got, input int want, input int idx);
		if (got != want)
			report_mismatch($sformatf("byte %0d %s got %0d, expected %0d", idx, name, got, want));
	endtask

	// Sender: track config writes, predict accepted samples, feed the next item in bursts
	always @(posedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_AMBIENT: cfg_ambient = cfg_data;
					REG_MARGIN:  cfg_margin = cfg_data;
					REG_STATION: cfg_station = cfg_data[BYTE_W-1:0];
					default: ;
				endcase
			end
			if (in_valid && !in_stall) begin
				decode_sample(sample);
				samples_taken++;
			end
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (sample_queue.size() != 0) begin
					in_valid <= 1'b1;
					sample <= sample_queue.pop_front();
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(48, 1);
						gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(8, 1);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Receiver: check each accepted byte, then pick the stall for the next cycle
	always @(posedge clk) begin : receiver
		ofd_result_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			if (out_valid && !out_stall) begin
				if (byte_expect.size() == 0) begin
					report_mismatch($sformatf("byte %0d arrived with nothing pending",
						byte_value));
				end else begin
					want = byte_expect.pop_front();
					check_field("byte_value", byte_value, want.byte_value, bytes_checked);
					check_field("byte_index", byte_index, want.byte_index, bytes_checked);
					check_field("frame_status", frame_status, want.frame_status, bytes_checked);
					check_field("frame_length", frame_length, want.frame_length, bytes_checked);
					check_field("destination", destination, want.destination, bytes_checked);
					check_field("origin_address", origin_address, want.origin_address,
						bytes_checked);
					check_field("last", last, want.last, bytes_checked);
					if (want.last)
						frames_seen[want.frame_status]++;
				end
				bytes_checked++;
			end
			if (hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (mode_left == 0) begin
				stall_mode = stall_mode_t'($urandom_range(3, 0));
				mode_left = $urandom_range(200, 16);
			end else begin
				mode_left--;
			end
			stall_tick++;
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				case (stall_mode)
					STALL_NONE:     out_stall <= 1'b0;
					STALL_LIGHT:    out_stall <= ($urandom_range(3, 0) == 0);
					STALL_HEAVY:    out_stall <= ($urandom_range(3, 0) != 0);
					STALL_PERIODIC: out_stall <= (stall_tick % 3 == 0);
					default:        out_stall <= 1'b0;
				endcase
			end
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("optical_frame_deframer_tb: timeout after %0d cycles", cycle_count);
			$display("optical_frame_deframer_tb: FAIL");
			$finish;
		end
	end

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		@(negedge clk);
	endtask

	// Hold until every queued sample is taken and every byte has come back
	task automatic wait_drained();
		do @(negedge clk);
		while (sample_queue.size() != 0 || in_valid || byte_expect.size() != 0);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Level that decodes to the wanted bit: light on (above threshold) is a 0
	function automatic logic [SAMPLE_W-1:0] bit_level(input logic b);
		logic [THR_W-1:0] thr;
		int top;
		int pick;
		thr = light_threshold();
		pick = $urandom_range(7, 0);
		if (!b && thr < SAMPLE_MAX) begin
			if (pick == 0)
				return SAMPLE_W'(thr + 1);
			if (pick == 1)
				return SAMPLE_W'(SAMPLE_MAX);
			return SAMPLE_W'($urandom_range(SAMPLE_MAX, thr + 1));
		end
		top = (thr > SAMPLE_MAX) ? SAMPLE_MAX : int'(thr);
		if (pick == 0)
			return SAMPLE_W'(top);
		if (pick == 1)
			return '0;
		return SAMPLE_W'($urandom_range(top, 0));
	endfunction

	// Idle-line samples that never start a frame
	task automatic push_noise(input int count);
		logic [THR_W-1:0] thr;
		int top;
		thr = light_threshold();
		top = (thr > SAMPLE_MAX) ? SAMPLE_MAX : int'(thr) - 1;
		if (thr != 0) begin
			for (int i = 0; i < count; i++)
				sample_queue.push_back(SAMPLE_W'($urandom_range(top, 0)));
		end
	endtask

	function automatic frame_bytes_t make_frame(input bit good_preamble, input logic [BYTE_W-1:0] dst);
		frame_bytes_t f;
		foreach (f[k])
			f[k] = BYTE_W'($urandom_range(255, 0));
		for (int k = 0; k <= int'(IDX_PREAMBLE_END); k++)
			f[k] = PREAMBLE_BYTE;
		if (!good_preamble)
			f[$urandom_range(int'(IDX_PREAMBLE_END), 0)] ^= BYTE_W'($urandom_range(255, 1));
		f[IDX_DEST] = dst;
		return f;
	endfunction

	// Queue a start mark and a whole frame; optionally stall the receiver or pause halfway
	task automatic send_frame(input frame_bytes_t content, input bit exact_start,
			input bit pause_mid, input bit with_hold);
		logic [THR_W-1:0] thr;
		thr = light_threshold();
		if (with_hold)
			hold_req++;
		if (exact_start)
			sample_queue.push_back(SAMPLE_W'(thr));
		else
			sample_queue.push_back(SAMPLE_W'($urandom_range(SAMPLE_MAX, thr)));
		for (int i = 0; i < FRAME_SAMPLES; i++) begin
			if (i % 2 == 0)
				sample_queue.push_back(bit_level(content[i / 16][7 - (i / 2) % 8]));
			else
				sample_queue.push_back(SAMPLE_W'($urandom_range(SAMPLE_MAX, 0)));
			if (pause_mid && i == FRAME_SAMPLES / 2 - 1)
				wait_drained();
		end
		wait_drained();
	endtask

	initial begin : stimulus
		int kind;
		logic [BYTE_W-1:0] dst;
		arst_n = 1'b0;
		in_valid = 1'b0;
		sample = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_AMBIENT;
		cfg_data = '0;
		cfg_ambient = AMBIENT_RESET;
		cfg_margin = MARGIN_RESET;
		cfg_station = STATION_RESET;
		rx_active = 1'b0;
		rx_count = '0;
		rx_shift = '0;
		rx_preamble_bad = 1'b0;
		rx_length = '0;
		rx_dest = '0;
		rx_source = '0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(negedge clk);

		// Directed: ignored register write, samples just under the threshold, start exactly on it
		write_reg(REG_UNUSED, CFG_DATA_W'(SAMPLE_MAX));
		sample_queue.push_back('0);
		sample_queue.push_back(SAMPLE_W'(MARGIN_RESET - 1));
		send_frame(make_frame(1'b1, STATION_RESET), 1'b1, 1'b1, 1'b0);

		// Threshold beyond the sample range: nothing may start
		write_reg(REG_AMBIENT, CFG_DATA_W'(SAMPLE_MAX));
		write_reg(REG_MARGIN, CFG_DATA_W'(SAMPLE_MAX));
		sample_queue.push_back(SAMPLE_W'(SAMPLE_MAX));
		sample_queue.push_back('0);
		push_noise(10);
		wait_drained();

		// Zero threshold: bad preamble wins over a wrong destination, under a long receiver hold
		write_reg(REG_AMBIENT, '0);
		write_reg(REG_MARGIN, '0);
		write_reg(REG_STATION, CFG_DATA_W'(SAMPLE_MAX));
		send_frame(make_frame(1'b0, 8'h00), 1'b1, 1'b0, 1'b1);

		// Station address zero, upper data bits set
		write_reg(REG_STATION, CFG_DATA_W'(10'h100));
		send_frame(make_frame(1'b1, 8'h00), 1'b0, 1'b0, 1'b0);

		// Random settings and frames
		for (int f = 0; f < RANDOM_FRAMES; f++) begin
			write_reg(REG_AMBIENT, CFG_DATA_W'($urandom_range(600, 0)));
			write_reg(REG_MARGIN, CFG_DATA_W'($urandom_range(400, 0)));
			write_reg(REG_STATION, CFG_DATA_W'($urandom_range(SAMPLE_MAX, 0)));
			push_noise($urandom_range(20, 0));
			kind = $urandom_range(9, 0);
			if (kind < 6)
				dst = cfg_station;
			else if (kind < 8)
				dst = ($urandom_range(1, 0) == 0) ? cfg_station : BYTE_W'($urandom_range(255, 0));
			else
				dst = cfg_station ^ BYTE_W'($urandom_range(255, 1));
			send_frame(make_frame(kind < 6 || kind >= 8, dst), 1'b0, f == 1, f == 2);
		end

		wait_drained();
		$display("optical_frame_deframer_tb: %0d samples taken, %0d bytes checked", samples_taken,
			bytes_checked);
		$display("optical_frame_deframer_tb: frames ok %0d, preamble error %0d, other destination %0d",
			frames_seen[STATUS_OK], frames_seen[STATUS_PREAMBLE], frames_seen[STATUS_OTHER_DST]);
		if (error_count == 0)
			$display("optical_frame_deframer_tb: PASS");
		else
			$display("optical_frame_deframer_tb: FAIL");
		$finish;
	end

endmodule

/* files.f */
hdl/ofd_pkg.sv
hdl/ofd_cfg_regs.sv
hdl/ofd_core.sv
hdl/optical_frame_deframer.sv
dv/optical_frame_deframer_tb.sv
